/* src/gspid_pkg.sv */
// Shared types, widths and constants for the gain-scheduled PID position loop.
// No dependencies; every other file refers to this package by scoped names.
package gspid_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 32;
    localparam int ERR_W      = 33;
    localparam int DER_W      = 34;
    localparam int CMP_W      = 36;
    localparam int GAIN_W     = 10;
    localparam int LIM_W      = 10;
    localparam int CMD_W      = 11;
    localparam int PE_W       = 44;
    localparam int PD_W       = 45;
    localparam int SUM_W      = 46;
    localparam int FRAC_W     = 16;
    localparam int QMAG_W     = SUM_W - FRAC_W;
    localparam int IMAG_W     = 26;
    localparam int IPROD_W    = IMAG_W + GAIN_W;

    localparam int SETTLE_TOLERANCE   = 328;
    localparam int INTEGRAL_WIDTH_DEF = 48;

    localparam logic [POS_W-1:0]  RST_TARGET    = '0;
    localparam logic [LIM_W-1:0]  RST_LIMIT     = LIM_W'(100);
    localparam logic [GAIN_W-1:0] RST_PD_POS_KP = GAIN_W'(175);
    localparam logic [GAIN_W-1:0] RST_PD_POS_KD = GAIN_W'(50);
    localparam logic [GAIN_W-1:0] RST_I_POS_KI  = GAIN_W'(150);
    localparam logic [GAIN_W-1:0] RST_PD_NEG_KP = GAIN_W'(100);
    localparam logic [GAIN_W-1:0] RST_PD_NEG_KD = GAIN_W'(25);
    localparam logic [GAIN_W-1:0] RST_I_NEG_KI  = GAIN_W'(80);

    typedef enum logic [2:0] {
        REG_TARGET    = 3'd0,
        REG_LIMIT     = 3'd1,
        REG_PD_POS_KP = 3'd2,
        REG_PD_POS_KD = 3'd3,
        REG_I_POS_KI  = 3'd4,
        REG_PD_NEG_KP = 3'd5,
        REG_PD_NEG_KD = 3'd6,
        REG_I_NEG_KI  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        SET_POS_PD = 2'd0,
        SET_POS_I  = 2'd1,
        SET_NEG_PD = 2'd2,
        SET_NEG_I  = 2'd3
    } t_gain_set;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  target;
        logic [LIM_W-1:0]  limit;
        logic [GAIN_W-1:0] pd_pos_kp;
        logic [GAIN_W-1:0] pd_pos_kd;
        logic [GAIN_W-1:0] i_pos_ki;
        logic [GAIN_W-1:0] pd_neg_kp;
        logic [GAIN_W-1:0] pd_neg_kd;
        logic [GAIN_W-1:0] i_neg_ki;
    } t_cfg;

    typedef struct packed {
        logic                    clr;
        logic signed [ERR_W-1:0] err;
        logic signed [DER_W-1:0] der;
        t_gain_set               set;
        logic                    settled;
    } t_s1;

    typedef struct packed {
        logic                   clr;
        t_gain_set              set;
        logic                   settled;
        logic signed [PE_W-1:0] pe;
        logic signed [PD_W-1:0] pd;
        logic [IPROD_W-1:0]     iprod;
        logic                   ibig;
        logic                   izero;
        logic                   ineg;
    } t_s2;

endpackage

/* src/gspid_cfg.sv */
// Configuration register file behind the APB-style port.
// Depends on gspid_pkg for the register map, reset values and t_cfg.
module gspid_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gspid_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gspid_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gspid_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output gspid_pkg::t_cfg                     o_cfg
);

    gspid_pkg::t_cfg      r_cfg;
    gspid_pkg::t_reg_idx  idx;
    logic                 wr;

    assign idx    = gspid_pkg::t_reg_idx'(paddr[gspid_pkg::CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target    <= gspid_pkg::RST_TARGET;
            r_cfg.limit     <= gspid_pkg::RST_LIMIT;
            r_cfg.pd_pos_kp <= gspid_pkg::RST_PD_POS_KP;
            r_cfg.pd_pos_kd <= gspid_pkg::RST_PD_POS_KD;
            r_cfg.i_pos_ki  <= gspid_pkg::RST_I_POS_KI;
            r_cfg.pd_neg_kp <= gspid_pkg::RST_PD_NEG_KP;
            r_cfg.pd_neg_kd <= gspid_pkg::RST_PD_NEG_KD;
            r_cfg.i_neg_ki  <= gspid_pkg::RST_I_NEG_KI;
        end else if (wr && pready) begin
            case (idx)
                gspid_pkg::REG_TARGET:    r_cfg.target    <= pwdata;
                gspid_pkg::REG_LIMIT:     r_cfg.limit     <= pwdata[gspid_pkg::LIM_W-1:0];
                gspid_pkg::REG_PD_POS_KP: r_cfg.pd_pos_kp <= pwdata[gspid_pkg::GAIN_W-1:0];
                gspid_pkg::REG_PD_POS_KD: r_cfg.pd_pos_kd <= pwdata[gspid_pkg::GAIN_W-1:0];
                gspid_pkg::REG_I_POS_KI:  r_cfg.i_pos_ki  <= pwdata[gspid_pkg::GAIN_W-1:0];
                gspid_pkg::REG_PD_NEG_KP: r_cfg.pd_neg_kp <= pwdata[gspid_pkg::GAIN_W-1:0];
                gspid_pkg::REG_PD_NEG_KD: r_cfg.pd_neg_kd <= pwdata[gspid_pkg::GAIN_W-1:0];
                gspid_pkg::REG_I_NEG_KI:  r_cfg.i_neg_ki  <= pwdata[gspid_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            gspid_pkg::REG_TARGET:    prdata = r_cfg.target;
            gspid_pkg::REG_LIMIT:     prdata = gspid_pkg::CFG_DATA_W'(r_cfg.limit);
            gspid_pkg::REG_PD_POS_KP: prdata = gspid_pkg::CFG_DATA_W'(r_cfg.pd_pos_kp);
            gspid_pkg::REG_PD_POS_KD: prdata = gspid_pkg::CFG_DATA_W'(r_cfg.pd_pos_kd);
            gspid_pkg::REG_I_POS_KI:  prdata = gspid_pkg::CFG_DATA_W'(r_cfg.i_pos_ki);
            gspid_pkg::REG_PD_NEG_KP: prdata = gspid_pkg::CFG_DATA_W'(r_cfg.pd_neg_kp);
            gspid_pkg::REG_PD_NEG_KD: prdata = gspid_pkg::CFG_DATA_W'(r_cfg.pd_neg_kd);
            gspid_pkg::REG_I_NEG_KI:  prdata = gspid_pkg::CFG_DATA_W'(r_cfg.i_neg_ki);
            default:                  prdata = '0;
        endcase
    end

endmodule

/* src/gspid_err.sv */
// Error stage: error, derivative, saturating integral, gain set and settle flag.
// Holds the loop state (previous error, integral). Depends on gspid_pkg.
module gspid_err #(
    parameter int INTEGRAL_WIDTH = gspid_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [gspid_pkg::POS_W-1:0]       i_meas,
    input  gspid_pkg::t_cfg                   i_cfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output gspid_pkg::t_s1                    o_s1,
    output logic signed [INTEGRAL_WIDTH-1:0]  o_integ
);

    localparam int ERR_W = gspid_pkg::ERR_W;
    localparam int CMP_W = gspid_pkg::CMP_W;
    localparam logic signed [INTEGRAL_WIDTH-1:0] I_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [INTEGRAL_WIDTH-1:0] I_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
    localparam logic signed [ERR_W-1:0] TOL = ERR_W'(gspid_pkg::SETTLE_TOLERANCE);

    logic                               r_v;
    gspid_pkg::t_s1                     r_s1;
    logic signed [ERR_W-1:0]            r_prev;
    logic signed [INTEGRAL_WIDTH-1:0]   r_integ;

    logic                               adv;
    logic signed [gspid_pkg::POS_W-1:0] sp;
    logic signed [gspid_pkg::POS_W:0]   sp2;
    logic signed [ERR_W+1:0]            e4;
    logic signed [CMP_W-1:0]            e4x;
    logic signed [CMP_W-1:0]            sp3;
    logic                               e_pos;
    logic signed [INTEGRAL_WIDTH:0]     isum;
    logic signed [INTEGRAL_WIDTH-1:0]   n_integ;
    gspid_pkg::t_s1                     n_s1;

    assign o_ready = !r_v || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_s1    = r_s1;
    assign o_integ = r_integ;

    always_comb begin
        sp    = $signed(i_cfg.target);
        sp2   = $signed({i_cfg.target, 1'b0});
        sp3   = CMP_W'(sp) + CMP_W'(sp2);
        n_s1.clr = (i_op == gspid_pkg::OP_CLEAR);
        n_s1.err = ERR_W'(sp) - ERR_W'($signed(i_meas));
        n_s1.der = gspid_pkg::DER_W'(n_s1.err) - gspid_pkg::DER_W'(r_prev);
        e4    = $signed({n_s1.err, 2'b00});
        e4x   = CMP_W'(e4);
        e_pos = !n_s1.err[ERR_W-1] && (n_s1.err != '0);
        if (e_pos) begin
            n_s1.set = (e4x < sp3) ? gspid_pkg::SET_POS_PD : gspid_pkg::SET_POS_I;
        end else begin
            n_s1.set = (e4x < -sp3) ? gspid_pkg::SET_NEG_PD : gspid_pkg::SET_NEG_I;
        end
        n_s1.settled = (n_s1.err <= TOL) && (n_s1.err >= -TOL);
        // saturate when the sign of the widened sum disagrees with the kept width
        isum = (INTEGRAL_WIDTH+1)'(r_integ) + (INTEGRAL_WIDTH+1)'(n_s1.err);
        if (isum[INTEGRAL_WIDTH] != isum[INTEGRAL_WIDTH-1]) begin
            n_integ = isum[INTEGRAL_WIDTH] ? I_MIN : I_MAX;
        end else begin
            n_integ = isum[INTEGRAL_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= 1'b0;
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (o_ready) begin
                r_v <= i_valid;
            end
            if (adv) begin
                if (n_s1.clr) begin
                    r_prev  <= '0;
                    r_integ <= '0;
                end else begin
                    r_prev  <= n_s1.err;
                    r_integ <= n_integ;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
        end
    end

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_s1.clr) |=> (r_prev == '0) && (r_integ == '0))
        else $error("loop state not cleared");

    a_integral_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !n_s1.clr && e_pos) |=> (r_integ >= $past(r_integ)))
        else $error("integral fell on positive error");

    a_integral_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !n_s1.clr && n_s1.err[ERR_W-1]) |=> (r_integ <= $past(r_integ)))
        else $error("integral rose on negative error");

endmodule

/* src/gspid_mul.sv */
// Product stage: gain selection and the three gain multiplies.
// Depends on gspid_pkg for t_cfg, t_s1, t_s2 and widths.
module gspid_mul #(
    parameter int INTEGRAL_WIDTH = gspid_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  gspid_pkg::t_s1                    i_s1,
    input  logic signed [INTEGRAL_WIDTH-1:0]  i_integ,
    input  gspid_pkg::t_cfg                   i_cfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output gspid_pkg::t_s2                    o_s2
);

    localparam int GAIN_W = gspid_pkg::GAIN_W;
    localparam int IMAG_W = gspid_pkg::IMAG_W;

    logic                        r_v;
    gspid_pkg::t_s2              r_s2;
    gspid_pkg::t_s2              n_s2;
    logic                        adv;
    logic                        pos;
    logic [GAIN_W-1:0]           kp;
    logic [GAIN_W-1:0]           kd;
    logic [GAIN_W-1:0]           ki;
    logic [INTEGRAL_WIDTH-1:0]   amag;

    assign o_ready = !r_v || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_v;
    assign o_s2    = r_s2;

    always_comb begin
        pos  = (i_s1.set == gspid_pkg::SET_POS_PD) || (i_s1.set == gspid_pkg::SET_POS_I);
        kp   = pos ? i_cfg.pd_pos_kp : i_cfg.pd_neg_kp;
        kd   = pos ? i_cfg.pd_pos_kd : i_cfg.pd_neg_kd;
        ki   = pos ? i_cfg.i_pos_ki  : i_cfg.i_neg_ki;
        // the most negative integral maps to 2^(W-1), still right as unsigned
        amag = i_integ[INTEGRAL_WIDTH-1] ? INTEGRAL_WIDTH'(-i_integ) : i_integ;
        n_s2.clr     = i_s1.clr;
        n_s2.set     = i_s1.set;
        n_s2.settled = i_s1.settled;
        n_s2.pe      = gspid_pkg::PE_W'(i_s1.err) * gspid_pkg::PE_W'($signed({1'b0, kp}));
        n_s2.pd      = gspid_pkg::PD_W'(i_s1.der) * gspid_pkg::PD_W'($signed({1'b0, kd}));
        n_s2.iprod   = gspid_pkg::IPROD_W'(amag[IMAG_W-1:0]) * gspid_pkg::IPROD_W'(ki);
        n_s2.ibig    = |amag[INTEGRAL_WIDTH-1:IMAG_W];
        n_s2.izero   = (ki == '0) || (amag == '0);
        n_s2.ineg    = i_integ[INTEGRAL_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2 <= n_s2;
        end
    end

endmodule

/* src/gspid_out.sv */
// Output stage: PD sum or integral term, truncation toward zero, clamp and the result register.
// Depends on gspid_pkg for t_s2, gain set codes and widths.
module gspid_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  gspid_pkg::t_s2                    i_s2,
    input  logic [gspid_pkg::LIM_W-1:0]       i_limit,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [gspid_pkg::CMD_W-1:0] o_cmd,
    output logic                              o_settled,
    output gspid_pkg::t_gain_set              o_set
);

    localparam int SUM_W  = gspid_pkg::SUM_W;
    localparam int QMAG_W = gspid_pkg::QMAG_W;
    localparam int FRAC_W = gspid_pkg::FRAC_W;
    localparam int LIM_W  = gspid_pkg::LIM_W;
    localparam int CMD_W  = gspid_pkg::CMD_W;

    logic                         r_v;
    logic signed [CMD_W-1:0]      r_cmd;
    logic                         r_settled;
    gspid_pkg::t_gain_set         r_set;

    logic                         adv;
    logic                         is_pd;
    logic signed [SUM_W-1:0]      sum;
    logic [SUM_W-1:0]             smag;
    logic [QMAG_W-1:0]            mag;
    logic                         neg;
    logic [LIM_W-1:0]             clamped;
    logic signed [CMD_W-1:0]      n_cmd;

    assign o_ready   = !r_v || i_ready;
    assign adv       = i_valid && o_ready;
    assign o_valid   = r_v;
    assign o_cmd     = r_cmd;
    assign o_settled = r_settled;
    assign o_set     = r_set;

    always_comb begin
        is_pd = (i_s2.set == gspid_pkg::SET_POS_PD) || (i_s2.set == gspid_pkg::SET_NEG_PD);
        sum   = SUM_W'(i_s2.pe) + SUM_W'(i_s2.pd);
        smag  = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
        if (is_pd) begin
            mag = smag[SUM_W-1:FRAC_W];
            neg = sum[SUM_W-1];
        end else if (i_s2.izero) begin
            mag = '0;
            neg = 1'b0;
        end else if (i_s2.ibig) begin
            mag = QMAG_W'(i_limit);
            neg = i_s2.ineg;
        end else begin
            mag = QMAG_W'(i_s2.iprod[gspid_pkg::IPROD_W-1:FRAC_W]);
            neg = i_s2.ineg;
        end
        clamped = (mag > QMAG_W'(i_limit)) ? i_limit : mag[LIM_W-1:0];
        n_cmd   = neg ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (i_s2.clr) begin
                r_cmd     <= '0;
                r_settled <= 1'b0;
                r_set     <= gspid_pkg::SET_POS_PD;
            end else begin
                r_cmd     <= n_cmd;
                r_settled <= i_s2.settled;
                r_set     <= i_s2.set;
            end
        end
    end

    a_cmd_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v |-> (r_cmd[CMD_W-1] ? (CMD_W'(-r_cmd) <= CMD_W'(i_limit))
                                : (r_cmd <= $signed(CMD_W'(i_limit)))))
        else $error("drive command beyond output limit");

endmodule

/* src/gain_scheduled_pid_position_loop.sv */
// A request accepted into the input register has its result valid once it has passed the error,
// product and output registers in that order; a stall can hold it in any of them.
// Throughput: one request per cycle while i_out_ready is high; each stage has its own valid and stalls only when full.
// Reset (i_rst_n low, synchronous) empties the pipe, zeroes previous error and integral,
// and loads the register defaults. Depends on gspid_pkg and the gspid_* stage modules.
module gain_scheduled_pid_position_loop #(
    parameter int INTEGRAL_WIDTH = gspid_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gspid_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gspid_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gspid_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_op,
    input  logic signed [gspid_pkg::POS_W-1:0]  i_measured_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [gspid_pkg::CMD_W-1:0]  o_drive_command,
    output logic                                o_settled,
    output logic [1:0]                          o_gain_set_used
);

    gspid_pkg::t_cfg                    cfg;
    logic                               r_in_v;
    logic                               r_op;
    logic [gspid_pkg::POS_W-1:0]        r_meas;
    logic                               err_ready;
    logic                               err_valid;
    gspid_pkg::t_s1                     s1;
    logic signed [INTEGRAL_WIDTH-1:0]   integ;
    logic                               mul_ready;
    logic                               mul_valid;
    gspid_pkg::t_s2                     s2;
    logic                               out_ready;
    gspid_pkg::t_gain_set               set_used;

    assign o_in_ready      = !r_in_v || err_ready;
    assign o_gain_set_used = set_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_in_ready) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op   <= i_op;
            r_meas <= i_measured_position;
        end
    end

    gspid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gspid_err #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .o_ready (err_ready),
        .i_op    (r_op),
        .i_meas  (r_meas),
        .i_cfg   (cfg),
        .o_valid (err_valid),
        .i_ready (mul_ready),
        .o_s1    (s1),
        .o_integ (integ)
    );

    gspid_mul #(.INTEGRAL_WIDTH(INTEGRAL_WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (err_valid),
        .o_ready (mul_ready),
        .i_s1    (s1),
        .i_integ (integ),
        .i_cfg   (cfg),
        .o_valid (mul_valid),
        .i_ready (out_ready),
        .o_s2    (s2)
    );

    gspid_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mul_valid),
        .o_ready   (out_ready),
        .i_s2      (s2),
        .i_limit   (cfg.limit),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_cmd     (o_drive_command),
        .o_settled (o_settled),
        .o_set     (set_used)
    );

endmodule
